[sv/rrsp_pkg.sv]
// Shared types and constants of the RESP2 reply stream parser.
`default_nettype none
package rrsp_pkg;

  localparam int LENGTH_WIDTH = 32;
  localparam int CMP_W = (LENGTH_WIDTH > 32) ? LENGTH_WIDTH : 32;
  localparam int INDEX_W = 31;

  localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {1'b0, {(LENGTH_WIDTH-1){1'b1}}};
  localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'(32'h7FFF_FFFF);

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_K      = 8'h4B;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_R      = 8'h52;

  localparam logic [2:0] PM_NONE  = 3'd0;
  localparam logic [2:0] PM_FIRST = 3'd1;
  localparam logic [2:0] PM_OK    = 3'd3;
  localparam logic [2:0] PM_ERR   = 3'd4;
  localparam logic [2:0] PM_FAIL  = 3'd7;

  typedef enum logic [2:0] {
    KIND_STATUS  = 3'd0,
    KIND_ERROR   = 3'd1,
    KIND_INTEGER = 3'd2,
    KIND_BULK    = 3'd3,
    KIND_ARRAY   = 3'd4,
    KIND_UNKNOWN = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NESTED       = 2'd1,
    ST_FRAMING      = 2'd2,
    ST_UNKNOWN_ELEM = 2'd3
  } status_t;

  typedef struct packed {
    logic                payload_valid;
    logic [7:0]          payload_byte;
    logic [INDEX_W-1:0]  element_index;
    logic                element_end;
    logic                element_null;
    kind_t               reply_kind;
    logic signed [31:0]  declared_count;
    logic                reply_done;
    status_t             parse_status;
    logic                ok_reply;
    logic                err_reply;
  } result_t;

endpackage
`default_nettype wire

[sv/rrsp_if.sv]
// Handshake channel interfaces for reply bytes and parse results.
`default_nettype none
interface rrsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       reply_start;

  modport source (output valid, output data_byte, output reply_start, input ready);
  modport sink (input valid, input data_byte, input reply_start, output ready);
endinterface

interface rrsp_result_if;
  logic               valid;
  logic               ready;
  logic               payload_valid;
  logic [7:0]         payload_byte;
  logic [30:0]        element_index;
  logic               element_end;
  logic               element_null;
  logic [2:0]         reply_kind;
  logic signed [31:0] declared_count;
  logic               reply_done;
  logic [1:0]         parse_status;
  logic               ok_reply;
  logic               err_reply;

  modport source (output valid, output payload_valid, output payload_byte,
                  output element_index, output element_end, output element_null,
                  output reply_kind, output declared_count, output reply_done,
                  output parse_status, output ok_reply, output err_reply,
                  input ready);
  modport sink (input valid, input payload_valid, input payload_byte,
                input element_index, input element_end, input element_null,
                input reply_kind, input declared_count, input reply_done,
                input parse_status, input ok_reply, input err_reply,
                output ready);
endinterface
`default_nettype wire

[sv/rrsp_core.sv]
// Per-byte parse state machine producing one result for each accepted byte.
`default_nettype none
module rrsp_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [7:0]       data_byte,
  input  wire logic             reply_start,
  output rrsp_pkg::result_t     result
);

  localparam int LW = rrsp_pkg::LENGTH_WIDTH;
  localparam int IW = rrsp_pkg::INDEX_W;

  typedef enum logic [3:0] {
    PH_TYPE, PH_LINE, PH_LINE_LF, PH_HLEN, PH_HLEN_LF, PH_BULK, PH_BULK_CR,
    PH_BULK_LF, PH_ETYPE, PH_EINT, PH_EINT_LF, PH_ELEN, PH_ELEN_LF, PH_DONE
  } phase_t;

  phase_t              parse_phase, parse_phase_next, cur_phase;
  rrsp_pkg::kind_t     reply_type_held, reply_type_held_next, cur_type;
  logic [LW-1:0]       length_accum, length_accum_next, cur_accum;
  logic                length_negative, length_negative_next, cur_negative;
  logic [LW-1:0]       bulk_remaining, bulk_remaining_next, cur_remaining;
  logic [IW-1:0]       elements_declared, elements_declared_next, cur_declared;
  logic [IW-1:0]       elements_seen, elements_seen_next, cur_seen;
  logic [2:0]          prefix_match, prefix_match_next, cur_prefix;

  logic [LW+3:0]       accum_prod;
  logic [3:0]          digit;
  logic [IW-1:0]       seen_inc;
  logic [rrsp_pkg::CMP_W-1:0] accum_ext, cur_accum_ext;
  logic                cur_null, next_null;
  logic                do_length, do_bulk, do_finish;
  logic                o_pv, o_end, o_null, o_done;
  logic [7:0]          o_pb;
  rrsp_pkg::status_t   o_status;
  logic [IW-1:0]       o_idx;
  logic [31:0]         o_dc;

  always_comb begin
    cur_phase     = reply_start ? PH_TYPE : parse_phase;
    cur_type      = reply_start ? rrsp_pkg::KIND_UNKNOWN : reply_type_held;
    cur_accum     = reply_start ? '0 : length_accum;
    cur_negative  = reply_start ? 1'b0 : length_negative;
    cur_remaining = reply_start ? '0 : bulk_remaining;
    cur_declared  = reply_start ? '0 : elements_declared;
    cur_seen      = reply_start ? '0 : elements_seen;
    cur_prefix    = reply_start ? rrsp_pkg::PM_NONE : prefix_match;
  end

  assign cur_null = cur_negative && (cur_accum != '0);
  assign digit = (data_byte inside {[rrsp_pkg::CH_0:rrsp_pkg::CH_9]}) ?
                 4'(data_byte - rrsp_pkg::CH_0) : 4'd0;
  assign accum_prod = {cur_accum, 3'b000} + {2'b00, cur_accum, 1'b0} + (LW+4)'(digit);
  assign cur_accum_ext = rrsp_pkg::CMP_W'(cur_accum);
  assign seen_inc = cur_seen + 1'b1;

  always_comb begin
    parse_phase_next       = cur_phase;
    reply_type_held_next   = cur_type;
    length_accum_next      = cur_accum;
    length_negative_next   = cur_negative;
    bulk_remaining_next    = cur_remaining;
    elements_declared_next = cur_declared;
    elements_seen_next     = cur_seen;
    prefix_match_next      = cur_prefix;
    do_length = 1'b0;
    do_bulk   = 1'b0;
    do_finish = 1'b0;
    o_pv      = 1'b0;
    o_pb      = 8'h00;
    o_end     = 1'b0;
    o_null    = 1'b0;
    o_done    = 1'b0;
    o_status  = rrsp_pkg::ST_OK;

    case (cur_phase)
      PH_TYPE: begin
        parse_phase_next = PH_LINE;
        case (data_byte)
          rrsp_pkg::CH_PLUS: begin
            reply_type_held_next = rrsp_pkg::KIND_STATUS;
            prefix_match_next = rrsp_pkg::PM_FIRST;
          end
          rrsp_pkg::CH_MINUS: begin
            reply_type_held_next = rrsp_pkg::KIND_ERROR;
            prefix_match_next = rrsp_pkg::PM_FIRST;
          end
          rrsp_pkg::CH_COLON: reply_type_held_next = rrsp_pkg::KIND_INTEGER;
          rrsp_pkg::CH_DOLLAR: begin
            reply_type_held_next = rrsp_pkg::KIND_BULK;
            parse_phase_next = PH_HLEN;
          end
          rrsp_pkg::CH_STAR: begin
            reply_type_held_next = rrsp_pkg::KIND_ARRAY;
            parse_phase_next = PH_HLEN;
          end
          default: begin
            reply_type_held_next = rrsp_pkg::KIND_UNKNOWN;
            parse_phase_next = PH_DONE;
            o_done = 1'b1;
            o_status = rrsp_pkg::ST_UNKNOWN_ELEM;
          end
        endcase
      end
      PH_LINE: begin
        if (data_byte == rrsp_pkg::CH_CR) begin
          parse_phase_next = PH_LINE_LF;
        end else begin
          o_pv = 1'b1;
          o_pb = data_byte;
          if (cur_type == rrsp_pkg::KIND_STATUS && cur_prefix >= rrsp_pkg::PM_FIRST &&
              cur_prefix < rrsp_pkg::PM_OK) begin
            prefix_match_next = (data_byte == ((cur_prefix == rrsp_pkg::PM_FIRST) ?
                                 rrsp_pkg::CH_O : rrsp_pkg::CH_K)) ?
                                cur_prefix + 3'd1 : rrsp_pkg::PM_FAIL;
          end else if (cur_type == rrsp_pkg::KIND_ERROR &&
                       cur_prefix >= rrsp_pkg::PM_FIRST && cur_prefix < rrsp_pkg::PM_ERR) begin
            prefix_match_next = (data_byte == ((cur_prefix == rrsp_pkg::PM_FIRST) ?
                                 rrsp_pkg::CH_E : rrsp_pkg::CH_R)) ?
                                cur_prefix + 3'd1 : rrsp_pkg::PM_FAIL;
          end
        end
      end
      PH_LINE_LF: begin
        parse_phase_next = PH_DONE;
        o_done = 1'b1;
        if (data_byte == rrsp_pkg::CH_LF) begin
          o_end = 1'b1;
        end else begin
          o_status = rrsp_pkg::ST_FRAMING;
        end
      end
      PH_HLEN, PH_ELEN: begin
        if (data_byte == rrsp_pkg::CH_CR) begin
          parse_phase_next = (cur_phase == PH_HLEN) ? PH_HLEN_LF : PH_ELEN_LF;
        end else begin
          do_length = 1'b1;
        end
      end
      PH_HLEN_LF: begin
        if (data_byte != rrsp_pkg::CH_LF) begin
          parse_phase_next = PH_DONE;
          o_done = 1'b1;
          o_status = rrsp_pkg::ST_FRAMING;
        end else if (cur_type == rrsp_pkg::KIND_BULK) begin
          do_bulk = 1'b1;
        end else if (cur_null || cur_accum == '0) begin
          parse_phase_next = PH_DONE;
          o_done = 1'b1;
        end else begin
          elements_declared_next = (cur_accum_ext > rrsp_pkg::CNT_MAX) ?
                                   IW'(rrsp_pkg::CNT_MAX) : IW'(cur_accum_ext);
          elements_seen_next = '0;
          parse_phase_next = PH_ETYPE;
        end
      end
      PH_ELEN_LF: begin
        if (data_byte == rrsp_pkg::CH_LF) begin
          do_bulk = 1'b1;
        end else begin
          parse_phase_next = PH_DONE;
          o_done = 1'b1;
          o_status = rrsp_pkg::ST_FRAMING;
        end
      end
      PH_BULK: begin
        o_pv = 1'b1;
        o_pb = data_byte;
        bulk_remaining_next = cur_remaining - 1'b1;
        if (cur_remaining == LW'(1)) begin
          parse_phase_next = PH_BULK_CR;
        end
      end
      PH_BULK_CR: begin
        if (data_byte == rrsp_pkg::CH_CR) begin
          parse_phase_next = PH_BULK_LF;
        end else begin
          parse_phase_next = PH_DONE;
          o_done = 1'b1;
          o_status = rrsp_pkg::ST_FRAMING;
        end
      end
      PH_BULK_LF, PH_EINT_LF: begin
        if (data_byte == rrsp_pkg::CH_LF) begin
          do_finish = 1'b1;
        end else begin
          parse_phase_next = PH_DONE;
          o_done = 1'b1;
          o_status = rrsp_pkg::ST_FRAMING;
        end
      end
      PH_ETYPE: begin
        case (data_byte)
          rrsp_pkg::CH_COLON: parse_phase_next = PH_EINT;
          rrsp_pkg::CH_DOLLAR: begin
            length_accum_next = '0;
            length_negative_next = 1'b0;
            parse_phase_next = PH_ELEN;
          end
          rrsp_pkg::CH_STAR: begin
            parse_phase_next = PH_DONE;
            o_done = 1'b1;
            o_status = rrsp_pkg::ST_NESTED;
          end
          default: begin
            parse_phase_next = PH_DONE;
            o_done = 1'b1;
            o_status = rrsp_pkg::ST_UNKNOWN_ELEM;
          end
        endcase
      end
      PH_EINT: begin
        if (data_byte == rrsp_pkg::CH_CR) begin
          parse_phase_next = PH_EINT_LF;
        end else begin
          o_pv = 1'b1;
          o_pb = data_byte;
        end
      end
      default: begin
        o_status = rrsp_pkg::ST_FRAMING;
      end
    endcase

    if (do_length) begin
      if (data_byte == rrsp_pkg::CH_MINUS && cur_accum == '0) begin
        length_negative_next = 1'b1;
      end else if (accum_prod > (LW+4)'(rrsp_pkg::LEN_MAX)) begin
        length_accum_next = rrsp_pkg::LEN_MAX;
      end else begin
        length_accum_next = accum_prod[LW-1:0];
      end
    end

    if (do_bulk) begin
      if (cur_null) begin
        o_null = 1'b1;
        do_finish = 1'b1;
      end else if (cur_accum == '0) begin
        parse_phase_next = PH_BULK_CR;
      end else begin
        bulk_remaining_next = cur_accum;
        parse_phase_next = PH_BULK;
      end
    end

    if (do_finish) begin
      o_end = 1'b1;
      if (cur_type == rrsp_pkg::KIND_ARRAY) begin
        elements_seen_next = seen_inc;
        if (seen_inc >= cur_declared) begin
          parse_phase_next = PH_DONE;
          o_done = 1'b1;
        end else begin
          parse_phase_next = PH_ETYPE;
        end
      end else begin
        parse_phase_next = PH_DONE;
        o_done = 1'b1;
      end
    end
  end

  assign o_idx = (cur_type == rrsp_pkg::KIND_ARRAY && cur_phase != PH_DONE) ? cur_seen : '0;
  assign next_null = length_negative_next && (length_accum_next != '0);
  assign accum_ext = rrsp_pkg::CMP_W'(length_accum_next);
  assign o_dc = next_null ? 32'hFFFF_FFFF :
                (accum_ext > rrsp_pkg::CNT_MAX) ? 32'(rrsp_pkg::CNT_MAX) : 32'(accum_ext);

  always_comb begin
    result.payload_valid  = o_pv;
    result.payload_byte   = o_pb;
    result.element_index  = o_idx;
    result.element_end    = o_end;
    result.element_null   = o_null;
    result.reply_kind     = reply_type_held_next;
    result.declared_count = o_dc;
    result.reply_done     = o_done;
    result.parse_status   = o_status;
    result.ok_reply       = (reply_type_held_next == rrsp_pkg::KIND_STATUS) &&
                            (prefix_match_next == rrsp_pkg::PM_OK);
    result.err_reply      = (reply_type_held_next == rrsp_pkg::KIND_ERROR) &&
                            (prefix_match_next == rrsp_pkg::PM_ERR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= PH_TYPE;
      reply_type_held   <= rrsp_pkg::KIND_UNKNOWN;
      length_accum      <= '0;
      length_negative   <= 1'b0;
      bulk_remaining    <= '0;
      elements_declared <= '0;
      elements_seen     <= '0;
      prefix_match      <= rrsp_pkg::PM_NONE;
    end else if (accept) begin
      parse_phase       <= parse_phase_next;
      reply_type_held   <= reply_type_held_next;
      length_accum      <= length_accum_next;
      length_negative   <= length_negative_next;
      bulk_remaining    <= bulk_remaining_next;
      elements_declared <= elements_declared_next;
      elements_seen     <= elements_seen_next;
      prefix_match      <= prefix_match_next;
    end
  end

endmodule
`default_nettype wire

[sv/rrsp_skid.sv]
// Two-entry result buffer that decouples the parser from the output channel.
`default_nettype none
module rrsp_skid (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire rrsp_pkg::result_t push_data,
  input  wire logic              pop,
  output logic                   full,
  output logic                   head_valid,
  output rrsp_pkg::result_t      head
);

  logic [1:0]        count;
  rrsp_pkg::result_t spare;

  assign full = (count == 2'd2);
  assign head_valid = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case (count)
        2'd0: begin
          if (push) begin
            count <= 2'd1;
          end
        end
        2'd1: begin
          if (push && !pop) begin
            count <= 2'd2;
          end else if (!push && pop) begin
            count <= 2'd0;
          end
        end
        default: begin
          if (pop) begin
            count <= 2'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (count == 2'd2) begin
      if (pop) begin
        head <= spare;
      end
    end else if (push && (count == 2'd0 || pop)) begin
      head <= push_data;
    end else if (push) begin
      spare <= push_data;
    end
  end

endmodule
`default_nettype wire

[sv/resp_reply_stream_parser_top.sv]
// Top level of the RESP2 reply stream parser.
//
//   Channel   Dir  Handshake       Item
//   data_in   in   valid / ready   data_byte, reply_start
//   results   out  valid / ready   one parse result per accepted byte
//
// Each accepted byte is parsed in the cycle it is taken; its result is registered
// in the result buffer; one byte per cycle is sustained while results are taken.
// The two-entry result buffer lets a byte be taken while one result waits.
// Synchronous reset returns the parser to waiting for a reply type byte and
// empties the buffer; no item is taken while both buffer entries are held.
`default_nettype none
module resp_reply_stream_parser_top (
  input  wire logic      clk,
  input  wire logic      rst,
  rrsp_byte_if.sink      data_in,
  rrsp_result_if.source  results
);

  rrsp_pkg::result_t parsed;
  rrsp_pkg::result_t head;
  logic              accept;
  logic              full;
  logic              head_valid;

  assign data_in.ready = !full;
  assign accept = data_in.valid && !full;

  rrsp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_in.data_byte),
    .reply_start (data_in.reply_start),
    .result      (parsed)
  );

  rrsp_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (parsed),
    .pop        (head_valid && results.ready),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  assign results.valid          = head_valid;
  assign results.payload_valid  = head.payload_valid;
  assign results.payload_byte   = head.payload_byte;
  assign results.element_index  = head.element_index;
  assign results.element_end    = head.element_end;
  assign results.element_null   = head.element_null;
  assign results.reply_kind     = head.reply_kind;
  assign results.declared_count = head.declared_count;
  assign results.reply_done     = head.reply_done;
  assign results.parse_status   = head.parse_status;
  assign results.ok_reply       = head.ok_reply;
  assign results.err_reply      = head.err_reply;

endmodule
`default_nettype wire

[verif/tb_resp_reply_stream_parser_top.sv]
// Self-checking testbench for the RESP2 reply stream parser top level.
`default_nettype none
module tb_resp_reply_stream_parser_top;

  localparam int RANDOM_ITEMS = 1700;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {
    P_TYPE, P_LINE, P_LINE_LF, P_HLEN, P_HLEN_LF, P_BULK, P_BULK_CR, P_BULK_LF,
    P_ETYPE, P_EINT, P_EINT_LF, P_ELEN, P_ELEN_LF, P_DONE
  } phase_e;

  typedef struct {
    logic [7:0]        data;
    logic              start;
    bit                typed;
    rrsp_pkg::result_t want;
  } stim_row_t;

  logic clk;
  logic rst;

  rrsp_byte_if   in_ch();
  rrsp_result_if out_ch();

  resp_reply_stream_parser_top dut (
    .clk(clk),
    .rst(rst),
    .data_in(in_ch),
    .results(out_ch)
  );

  phase_e             ph = P_TYPE;
  rrsp_pkg::kind_t    cur_kind = rrsp_pkg::KIND_UNKNOWN;
  logic [63:0]        len_acc = '0;
  bit                 len_neg = 1'b0;
  logic [63:0]        bulk_left = '0;
  logic [31:0]        elem_decl = '0;
  logic [31:0]        elem_seen = '0;
  logic [2:0]         pfx = rrsp_pkg::PM_NONE;
  bit                 r_end;
  bit                 r_null;
  bit                 r_done;
  rrsp_pkg::status_t  r_stat;

  rrsp_pkg::result_t results_due[$];
  stim_row_t         dir_rows[$];
  logic [7:0]        reply_bytes[$];

  int send_pct = 17;
  int recv_pct = 50;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int mismatches = 0;
  int cycles = 0;
  int items_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, results_due.size());
      $display("resp_reply_stream_parser_top regression: fail");
      $finish;
    end
  end

  function automatic void end_reply(rrsp_pkg::status_t st);
    ph = P_DONE;
    r_done = 1'b1;
    r_stat = st;
  endfunction

  function automatic bit len_is_null();
    return len_neg && (len_acc != 0);
  endfunction

  function automatic void close_element();
    r_end = 1'b1;
    if (cur_kind == rrsp_pkg::KIND_ARRAY) begin
      if (elem_seen != 32'hFFFF_FFFF) elem_seen++;
      if (elem_seen >= elem_decl) end_reply(rrsp_pkg::ST_OK);
      else ph = P_ETYPE;
    end else begin
      end_reply(rrsp_pkg::ST_OK);
    end
  endfunction

  function automatic void open_bulk();
    if (len_is_null()) begin
      r_null = 1'b1;
      close_element();
    end else if (len_acc == 0) begin
      ph = P_BULK_CR;
    end else begin
      bulk_left = len_acc;
      ph = P_BULK;
    end
  endfunction

  function automatic void take_len_char(logic [7:0] b);
    logic [63:0] d;
    logic [63:0] lim;
    lim = 64'(rrsp_pkg::LEN_MAX);
    if (b == rrsp_pkg::CH_MINUS && len_acc == 0) begin
      len_neg = 1'b1;
      return;
    end
    d = (b >= rrsp_pkg::CH_0 && b <= rrsp_pkg::CH_9) ? 64'(b - rrsp_pkg::CH_0) : 64'd0;
    if (len_acc > (lim - d) / 10) len_acc = lim;
    else len_acc = len_acc * 10 + d;
  endfunction

  function automatic void track_prefix(logic [7:0] b);
    logic [7:0] want;
    if (cur_kind == rrsp_pkg::KIND_STATUS && pfx >= rrsp_pkg::PM_FIRST &&
        pfx < rrsp_pkg::PM_OK) begin
      want = (pfx == rrsp_pkg::PM_FIRST) ? rrsp_pkg::CH_O : rrsp_pkg::CH_K;
    end else if (cur_kind == rrsp_pkg::KIND_ERROR && pfx >= rrsp_pkg::PM_FIRST &&
                 pfx < rrsp_pkg::PM_ERR) begin
      want = (pfx == rrsp_pkg::PM_FIRST) ? rrsp_pkg::CH_E : rrsp_pkg::CH_R;
    end else begin
      return;
    end
    pfx = (b == want) ? pfx + 3'd1 : rrsp_pkg::PM_FAIL;
  endfunction

  function automatic rrsp_pkg::result_t parse_byte(logic [7:0] b, logic s);
    rrsp_pkg::result_t r;
    logic [63:0]       cnt;
    if (s) begin
      ph = P_TYPE;
      cur_kind = rrsp_pkg::KIND_UNKNOWN;
      len_acc = '0;
      len_neg = 1'b0;
      bulk_left = '0;
      elem_decl = '0;
      elem_seen = '0;
      pfx = rrsp_pkg::PM_NONE;
    end
    r = '0;
    r_end = 1'b0;
    r_null = 1'b0;
    r_done = 1'b0;
    r_stat = rrsp_pkg::ST_OK;
    r.element_index = (cur_kind == rrsp_pkg::KIND_ARRAY && ph != P_DONE) ?
                      elem_seen[30:0] : '0;
    case (ph)
      P_TYPE: begin
        case (b)
          rrsp_pkg::CH_PLUS: begin
            cur_kind = rrsp_pkg::KIND_STATUS;
            pfx = rrsp_pkg::PM_FIRST;
            ph = P_LINE;
          end
          rrsp_pkg::CH_MINUS: begin
            cur_kind = rrsp_pkg::KIND_ERROR;
            pfx = rrsp_pkg::PM_FIRST;
            ph = P_LINE;
          end
          rrsp_pkg::CH_COLON: begin
            cur_kind = rrsp_pkg::KIND_INTEGER;
            ph = P_LINE;
          end
          rrsp_pkg::CH_DOLLAR: begin
            cur_kind = rrsp_pkg::KIND_BULK;
            ph = P_HLEN;
          end
          rrsp_pkg::CH_STAR: begin
            cur_kind = rrsp_pkg::KIND_ARRAY;
            ph = P_HLEN;
          end
          default: begin
            cur_kind = rrsp_pkg::KIND_UNKNOWN;
            end_reply(rrsp_pkg::ST_UNKNOWN_ELEM);
          end
        endcase
      end
      P_LINE: begin
        if (b == rrsp_pkg::CH_CR) begin
          ph = P_LINE_LF;
        end else begin
          r.payload_valid = 1'b1;
          r.payload_byte = b;
          track_prefix(b);
        end
      end
      P_LINE_LF: begin
        if (b == rrsp_pkg::CH_LF) begin
          r_end = 1'b1;
          end_reply(rrsp_pkg::ST_OK);
        end else begin
          end_reply(rrsp_pkg::ST_FRAMING);
        end
      end
      P_HLEN: begin
        if (b == rrsp_pkg::CH_CR) ph = P_HLEN_LF;
        else take_len_char(b);
      end
      P_ELEN: begin
        if (b == rrsp_pkg::CH_CR) ph = P_ELEN_LF;
        else take_len_char(b);
      end
      P_HLEN_LF: begin
        if (b != rrsp_pkg::CH_LF) begin
          end_reply(rrsp_pkg::ST_FRAMING);
        end else if (cur_kind == rrsp_pkg::KIND_BULK) begin
          open_bulk();
        end else if (len_is_null() || len_acc == 0) begin
          end_reply(rrsp_pkg::ST_OK);
        end else begin
          elem_decl = (len_acc > 64'(rrsp_pkg::CNT_MAX)) ? 32'(rrsp_pkg::CNT_MAX) :
                      len_acc[31:0];
          elem_seen = '0;
          ph = P_ETYPE;
        end
      end
      P_ELEN_LF: begin
        if (b == rrsp_pkg::CH_LF) open_bulk();
        else end_reply(rrsp_pkg::ST_FRAMING);
      end
      P_BULK: begin
        r.payload_valid = 1'b1;
        r.payload_byte = b;
        if (bulk_left > 0) bulk_left--;
        if (bulk_left == 0) ph = P_BULK_CR;
      end
      P_BULK_CR: begin
        if (b == rrsp_pkg::CH_CR) ph = P_BULK_LF;
        else end_reply(rrsp_pkg::ST_FRAMING);
      end
      P_BULK_LF, P_EINT_LF: begin
        if (b == rrsp_pkg::CH_LF) close_element();
        else end_reply(rrsp_pkg::ST_FRAMING);
      end
      P_ETYPE: begin
        case (b)
          rrsp_pkg::CH_COLON: ph = P_EINT;
          rrsp_pkg::CH_DOLLAR: begin
            len_acc = '0;
            len_neg = 1'b0;
            ph = P_ELEN;
          end
          rrsp_pkg::CH_STAR: end_reply(rrsp_pkg::ST_NESTED);
          default: end_reply(rrsp_pkg::ST_UNKNOWN_ELEM);
        endcase
      end
      P_EINT: begin
        if (b == rrsp_pkg::CH_CR) begin
          ph = P_EINT_LF;
        end else begin
          r.payload_valid = 1'b1;
          r.payload_byte = b;
        end
      end
      default: r_stat = rrsp_pkg::ST_FRAMING;
    endcase
    cnt = (len_acc > 64'(rrsp_pkg::CNT_MAX)) ? 64'(rrsp_pkg::CNT_MAX) : len_acc;
    r.declared_count = len_is_null() ? 32'hFFFF_FFFF : cnt[31:0];
    r.element_end = r_end;
    r.element_null = r_null;
    r.reply_kind = cur_kind;
    r.reply_done = r_done;
    r.parse_status = r_stat;
    r.ok_reply = (cur_kind == rrsp_pkg::KIND_STATUS && pfx == rrsp_pkg::PM_OK);
    r.err_reply = (cur_kind == rrsp_pkg::KIND_ERROR && pfx == rrsp_pkg::PM_ERR);
    return r;
  endfunction

  function automatic rrsp_pkg::result_t typed_res(rrsp_pkg::kind_t k, rrsp_pkg::status_t st,
                                                  logic done, logic [30:0] idx,
                                                  logic signed [31:0] dc);
    rrsp_pkg::result_t r;
    r = '0;
    r.reply_kind = k;
    r.parse_status = st;
    r.reply_done = done;
    r.element_index = idx;
    r.declared_count = dc;
    return r;
  endfunction

  task automatic push_row(logic [7:0] b, logic s);
    stim_row_t row;
    row.data = b;
    row.start = s;
    row.typed = 1'b0;
    row.want = '0;
    dir_rows.push_back(row);
  endtask

  task automatic push_typed(logic [7:0] b, logic s, rrsp_pkg::result_t want);
    stim_row_t row;
    row.data = b;
    row.start = s;
    row.typed = 1'b1;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    rrsp_pkg::result_t want;
    if (results_due.size() == 0) begin
      $display("%0t: result with no byte outstanding, got kind %0h status %0h", $time,
               out_ch.reply_kind, out_ch.parse_status);
      mismatches++;
      return;
    end
    want = results_due.pop_front();
    check_field("payload_valid", 32'(want.payload_valid), 32'(out_ch.payload_valid));
    check_field("payload_byte", 32'(want.payload_byte), 32'(out_ch.payload_byte));
    check_field("element_index", 32'(want.element_index), 32'(out_ch.element_index));
    check_field("element_end", 32'(want.element_end), 32'(out_ch.element_end));
    check_field("element_null", 32'(want.element_null), 32'(out_ch.element_null));
    check_field("reply_kind", 32'(want.reply_kind), 32'(out_ch.reply_kind));
    check_field("declared_count", want.declared_count, out_ch.declared_count);
    check_field("reply_done", 32'(want.reply_done), 32'(out_ch.reply_done));
    check_field("parse_status", 32'(want.parse_status), 32'(out_ch.parse_status));
    check_field("ok_reply", 32'(want.ok_reply), 32'(out_ch.ok_reply));
    check_field("err_reply", 32'(want.err_reply), 32'(out_ch.err_reply));
  endtask

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) check_result();
  end

  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_pct);
    end
  end

  task automatic send_item(logic [7:0] b, logic s, bit typed, rrsp_pkg::result_t want);
    rrsp_pkg::result_t got;
    while ($urandom_range(99) < send_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.reply_start <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    got = parse_byte(b, s);
    results_due.push_back(typed ? want : got);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic set_mode(int sp, int rp, bit hold);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    send_pct = sp;
    recv_pct = rp;
    hold_req = hold;
    @(negedge clk);
  endtask

  task automatic put(logic [7:0] b);
    reply_bytes.push_back(b);
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic put_crlf();
    put(rrsp_pkg::CH_CR);
    put(rrsp_pkg::CH_LF);
  endtask

  task automatic put_text(int n);
    logic [7:0] c;
    repeat (n) begin
      c = 8'($urandom_range(255));
      put((c == rrsp_pkg::CH_CR) ? rrsp_pkg::CH_LF : c);
    end
  endtask

  task automatic put_len(int n);
    if (n < 0) begin
      put(rrsp_pkg::CH_MINUS);
      put_str($sformatf("%0d", $urandom_range(1, 999)));
    end else if (n == 0 && $urandom_range(3) == 0) begin
      put_str("-0");
    end else begin
      put_str($sformatf("%0d", n));
    end
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 10) return -1;
    if (r < 90) return $urandom_range(5);
    return $urandom_range(6, 40);
  endfunction

  task automatic put_bulk(int n);
    put(rrsp_pkg::CH_DOLLAR);
    put_len(n);
    put_crlf();
    if (n >= 0) begin
      repeat (n) put(8'($urandom_range(255)));
      put_crlf();
    end
  endtask

  task automatic put_int_line();
    put(rrsp_pkg::CH_COLON);
    if ($urandom_range(1)) put(rrsp_pkg::CH_MINUS);
    repeat ($urandom_range(6)) begin
      if ($urandom_range(9) == 0) put_text(1);
      else put(8'(rrsp_pkg::CH_0 + $urandom_range(9)));
    end
    put_crlf();
  endtask

  task automatic build_reply(output bit noise);
    int n;
    int r;
    noise = 1'b0;
    reply_bytes.delete();
    case ($urandom_range(9))
      0: begin
        put(rrsp_pkg::CH_PLUS);
        if ($urandom_range(99) < 60) put_str("OK");
        put_text($urandom_range(4));
        put_crlf();
      end
      1: begin
        put(rrsp_pkg::CH_MINUS);
        r = $urandom_range(99);
        if (r < 50) put_str("ERR");
        else if (r < 70) put_str("ER");
        put_text($urandom_range(4));
        put_crlf();
      end
      2: put_int_line();
      3, 4: put_bulk(pick_len());
      5, 6, 7: begin
        r = $urandom_range(99);
        n = (r < 10) ? -1 : (r < 20) ? 0 : $urandom_range(1, 4);
        put(rrsp_pkg::CH_STAR);
        put_len(n);
        put_crlf();
        for (int i = 0; i < n; i++) begin
          r = $urandom_range(99);
          if (r < 4) begin
            put(rrsp_pkg::CH_STAR);
            break;
          end else if (r < 8) begin
            put(($urandom_range(2) == 0) ? rrsp_pkg::CH_PLUS :
                ($urandom_range(1) ? rrsp_pkg::CH_MINUS : 8'($urandom_range(255))));
            break;
          end else if (r < 50) begin
            put_int_line();
          end else begin
            put_bulk(pick_len());
          end
        end
      end
      8: begin
        r = $urandom_range(1);
        put(r ? rrsp_pkg::CH_STAR : rrsp_pkg::CH_DOLLAR);
        put(8'(rrsp_pkg::CH_0 + $urandom_range(1, 9)));
        repeat ($urandom_range(9, 11)) put(8'(rrsp_pkg::CH_0 + $urandom_range(9)));
        put_crlf();
        if (r) begin
          put_int_line();
          put_int_line();
        end else begin
          put_text($urandom_range(1, 4));
        end
      end
      default: begin
        noise = 1'b1;
        repeat ($urandom_range(1, 5)) put(8'($urandom_range(255)));
      end
    endcase
    if (!noise) begin
      r = $urandom_range(99);
      if (r < 10) begin
        reply_bytes[$urandom_range(reply_bytes.size() - 1)] = 8'($urandom_range(255));
      end else if (r < 15) begin
        n = $urandom_range(1, reply_bytes.size());
        while (reply_bytes.size() > n) void'(reply_bytes.pop_back());
      end else if (r < 22) begin
        repeat ($urandom_range(1, 3)) put(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic send_reply();
    bit noise;
    build_reply(noise);
    for (int i = 0; i < reply_bytes.size(); i++) begin
      send_item(reply_bytes[i], noise ? 1'($urandom_range(1)) : (i == 0), 1'b0, '0);
    end
  endtask

  initial begin
    int base;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.reply_start = 1'b0;

    push_typed(8'hFF, 1'b1, typed_res(rrsp_pkg::KIND_UNKNOWN, rrsp_pkg::ST_UNKNOWN_ELEM,
                                      1'b1, '0, 0));
    push_typed(8'h00, 1'b0, typed_res(rrsp_pkg::KIND_UNKNOWN, rrsp_pkg::ST_FRAMING,
                                      1'b0, '0, 0));
    push_row(rrsp_pkg::CH_PLUS, 1'b1);
    push_row(rrsp_pkg::CH_O, 1'b0);
    push_row(rrsp_pkg::CH_K, 1'b0);
    push_row(rrsp_pkg::CH_LF, 1'b0);
    push_row(rrsp_pkg::CH_CR, 1'b0);
    push_row(rrsp_pkg::CH_LF, 1'b0);
    push_row(rrsp_pkg::CH_COLON, 1'b1);
    push_row(rrsp_pkg::CH_CR, 1'b0);
    push_row(rrsp_pkg::CH_LF, 1'b0);
    push_row(rrsp_pkg::CH_MINUS, 1'b1);
    push_row(rrsp_pkg::CH_CR, 1'b0);
    push_typed(8'h00, 1'b0, typed_res(rrsp_pkg::KIND_ERROR, rrsp_pkg::ST_FRAMING,
                                      1'b1, '0, 0));
    push_row(rrsp_pkg::CH_STAR, 1'b1);
    push_row(rrsp_pkg::CH_MINUS, 1'b0);
    push_row(rrsp_pkg::CH_0, 1'b0);
    push_row(rrsp_pkg::CH_CR, 1'b0);
    push_typed(rrsp_pkg::CH_LF, 1'b0, typed_res(rrsp_pkg::KIND_ARRAY, rrsp_pkg::ST_OK,
                                                1'b1, '0, 0));
    push_row(rrsp_pkg::CH_STAR, 1'b1);
    push_row(rrsp_pkg::CH_0 + 8'd2, 1'b0);
    push_row(rrsp_pkg::CH_CR, 1'b0);
    push_row(rrsp_pkg::CH_LF, 1'b0);
    push_row(rrsp_pkg::CH_DOLLAR, 1'b0);
    push_row(rrsp_pkg::CH_MINUS, 1'b0);
    push_row(rrsp_pkg::CH_0 + 8'd5, 1'b0);
    push_row(rrsp_pkg::CH_CR, 1'b0);
    push_row(rrsp_pkg::CH_LF, 1'b0);
    push_typed(rrsp_pkg::CH_STAR, 1'b0, typed_res(rrsp_pkg::KIND_ARRAY, rrsp_pkg::ST_NESTED,
                                                  1'b1, 31'd1, -1));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].data, dir_rows[i].start, dir_rows[i].typed, dir_rows[i].want);
    end

    base = items_sent;
    for (int stage = 0; stage < 3; stage++) begin
      if (stage == 1) set_mode(50, 17, 1'b0);
      if (stage == 2) set_mode(0, 0, 1'b1);
      while (items_sent < base + (stage + 1) * RANDOM_ITEMS / 3) send_reply();
    end
    in_ch.valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("resp_reply_stream_parser_top regression: pass");
    end else begin
      $display("resp_reply_stream_parser_top regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
